@@ rtl/pfc_pkg.sv @@
// Shared constants and types for the padded frame CRC-7 builder.
package pfc_pkg;

    localparam int FRAME_BYTES = 64;
    localparam int CNT_W       = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(FRAME_BYTES - 1);
    localparam logic [7:0] CRC_POLY  = 8'h91;
    localparam int STEP_W      = 3;

    typedef struct packed {
        logic       start;
        logic       clear;
        logic [7:0] data;
    } t_crc_ctl;

    typedef struct packed {
        logic       busy;
        logic [7:0] crc;
    } t_crc_stat;

endpackage

@@ rtl/pfc_crc.sv @@
// Bit-serial reflected CRC-7 folder: one polynomial step per cycle.
module pfc_crc (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pfc_pkg::t_crc_ctl  i_ctl,
    output pfc_pkg::t_crc_stat o_stat
);
    import pfc_pkg::*;

    logic [7:0]        r_crc;
    logic [7:0]        n_crc;
    logic [STEP_W-1:0] r_steps;
    logic [STEP_W-1:0] n_steps;

    function automatic logic [7:0] crc_step(input logic [7:0] c);
        logic [7:0] t;
        t = c[0] ? (c ^ CRC_POLY) : c;
        return {1'b0, t[7:1]};
    endfunction

    always_comb begin
        n_crc   = r_crc;
        n_steps = r_steps;
        if (i_ctl.clear) begin
            n_crc   = 8'h00;
            n_steps = '0;
        end else if (i_ctl.start) begin
            n_crc   = crc_step(r_crc ^ i_ctl.data);
            n_steps = STEP_W'(7);
        end else if (r_steps != '0) begin
            n_crc   = crc_step(r_crc);
            n_steps = r_steps - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= 8'h00;
            r_steps <= '0;
        end else begin
            r_crc   <= n_crc;
            r_steps <= n_steps;
        end
    end

    assign o_stat.busy = (r_steps != '0);
    assign o_stat.crc  = r_crc;

endmodule

@@ rtl/padded_frame_crc7_builder.sv @@
// Top level: frame sequencer, output register and bit-serial CRC-7 unit.
// Usage:
//   Input channel (i_in_valid/o_in_ready) carries one word: i_kind and
//   i_data_byte. Kind 0 is a message byte, kind 1 ends the message.
//   Output channel (o_out_valid/i_out_ready) carries frame bytes in send
//   order: message bytes, zero pads, then the CRC byte with o_frame_last
//   high and o_truncated set if message bytes beyond 63 were dropped.
//   Every frame is 64 bytes long.
// A taken message byte passes the pending register, then the output register.
// The input takes no word while a byte waits for output or while the CRC
//   unit, which folds one bit per cycle, is busy. An end-of-message word
//   then yields zero pads, each waiting for the CRC unit, and the CRC byte.
// Bytes beyond 63 are dropped on intake and produce no output.
// Reset clears the byte count, CRC and overflow flag and empties the output.
// A stalled receiver holds the output register; the block takes one more
//   word into its pending slot and then waits until the output frees.
module padded_frame_crc7_builder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_kind,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_frame_last,
    output logic       o_truncated
);
    import pfc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_PAD,
        ST_CRC
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [7:0]       r_pend, n_pend;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_last, n_out_last;
    logic             r_out_trunc, n_out_trunc;

    t_crc_ctl  crc_ctl;
    t_crc_stat crc_stat;
    logic      slot_free;
    logic      in_take;

    pfc_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .o_stat  (crc_stat)
    );

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && !crc_stat.busy;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_trunc = r_out_trunc;
        crc_ctl     = '{start: 1'b0, clear: 1'b0, data: 8'h00};
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (i_kind) begin
                        n_state = (r_count != CAP) ? ST_PAD : ST_CRC;
                    end else if (r_count != CAP) begin
                        crc_ctl.start = 1'b1;
                        crc_ctl.data  = i_data_byte;
                        n_pend        = i_data_byte;
                        n_count       = r_count + CNT_W'(1);
                        n_state       = ST_EMIT;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_pend;
                    n_out_last  = 1'b0;
                    n_out_trunc = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            ST_PAD: begin
                if (slot_free && !crc_stat.busy) begin
                    crc_ctl.start = 1'b1;
                    n_out_valid   = 1'b1;
                    n_out_byte    = 8'h00;
                    n_out_last    = 1'b0;
                    n_out_trunc   = 1'b0;
                    n_count       = r_count + CNT_W'(1);
                    if (r_count == CAP - CNT_W'(1)) begin
                        n_state = ST_CRC;
                    end
                end
            end
            ST_CRC: begin
                if (slot_free && !crc_stat.busy) begin
                    crc_ctl.clear = 1'b1;
                    n_out_valid   = 1'b1;
                    n_out_byte    = crc_stat.crc;
                    n_out_last    = 1'b1;
                    n_out_trunc   = r_ovf;
                    n_count       = '0;
                    n_ovf         = 1'b0;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_pend      <= n_pend;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_trunc <= n_out_trunc;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_frame_last = r_out_last;
    assign o_truncated  = r_out_trunc;

`ifndef SYNTHESIS
    a_ready_crc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !crc_stat.busy)
        else $error("input ready while CRC unit busy");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("byte count beyond frame capacity");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_truncated) |-> o_frame_last)
        else $error("truncated flag on a non-final byte");

    a_crc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        crc_ctl.clear |=> (r_count == '0 || $past(in_take)) && !r_ovf)
        else $error("state not cleared after frame close");
`endif

endmodule
